>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers on clk_i / rst_ni. Empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clk_i edge outside reset.
`define PBR1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset.
`define PBR1_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PBR1_ASSERT(lbl, prop, msg)
`define PBR1_NEVER(lbl, cond, msg)
`endif

`endif

>>> src/pbr1_pkg.sv
// ---------------------------------------------------------------------------
// pbr1_pkg
// Shared types and constants of the planar run-length body decoder.
// ---------------------------------------------------------------------------
package pbr1_pkg;

  localparam int unsigned MaxBytesPerRow = 8192;
  localparam int unsigned MaxPlanes      = 8;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgAddrW-1:0] {
    REG_BYTES_PER_ROW = 2'd0,
    REG_NUM_PLANES    = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2
  } reg_addr_e;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_RUN     = 2'd1,
    MODE_LITERAL = 2'd2
  } mode_e;

endpackage

>>> src/pbr1_if.sv
// ---------------------------------------------------------------------------
// pbr1 channel interfaces
// Valid/ready channels: compressed byte in, decoded write out, register write.
// ---------------------------------------------------------------------------
interface pbr1_in_if;
  logic       valid;
  logic       ready;
  logic       start_frame;
  logic [7:0] compressed_byte;

  modport source (output valid, output start_frame, output compressed_byte, input ready);
  modport sink   (input valid, input start_frame, input compressed_byte, output ready);
endinterface

interface pbr1_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value;
  logic [7:0]  repeat_res;
  logic [2:0]  plane;
  logic [15:0] row;
  logic [12:0] column;
  logic        line_end;
  logic        frame_end;
  logic        format_error;

  modport source (output valid, output value, output repeat_res, output plane, output row,
                  output column, output line_end, output frame_end, output format_error,
                  input ready);
  modport sink   (input valid, input value, input repeat_res, input plane, input row,
                  input column, input line_end, input frame_end, input format_error,
                  output ready);
endinterface

interface pbr1_cfg_if;
  import pbr1_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

>>> src/planar_byterun1_body_decoder_unit.sv
// An accepted byte sits in the input register; its result (if any) is written to the result register.
// Throughput: one compressed byte per cycle unless the output stalls; the decode state
//   loop closes in the single compute stage between the input and result registers.
// Reset (rst_ni low, async): position, mode and halt cleared, registers back to
//   40 bytes per row, 5 planes, 200 rows; both pipeline registers empty.
// ---------------------------------------------------------------------------
// planar_byterun1_body_decoder_unit
// ByteRun1 decoder for an interleaved bitplane body, one byte per beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module planar_byterun1_body_decoder_unit
  import pbr1_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  pbr1_cfg_if.sink       cfg_i,
  pbr1_in_if.sink        in_i,
  pbr1_out_if.source     out_o
);

  localparam logic [13:0] LineMax  = 14'(MaxBytesPerRow);
  localparam logic [3:0]  PlaneMax = 4'(MaxPlanes);

  // ---------------- configuration registers ----------------
  logic [13:0] bpr_q;
  logic [3:0]  planes_q;
  logic [15:0] height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q    <= 14'd40;
      planes_q <= 4'd5;
      height_q <= 16'd200;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        REG_BYTES_PER_ROW: bpr_q    <= cfg_i.wdata[13:0];
        REG_NUM_PLANES:    planes_q <= cfg_i.wdata[3:0];
        REG_IMAGE_HEIGHT:  height_q <= cfg_i.wdata[15:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // Clamped line length and plane count.
  logic [13:0] line_len;
  logic [3:0]  plane_cnt;

  always_comb begin
    if (bpr_q == 14'd0)      line_len = 14'd1;
    else if (bpr_q > LineMax) line_len = LineMax;
    else                      line_len = bpr_q;
    if (planes_q == 4'd0)         plane_cnt = 4'd1;
    else if (planes_q > PlaneMax) plane_cnt = PlaneMax;
    else                          plane_cnt = planes_q;
  end

  // ---------------- input register ----------------
  logic       in_v_q;
  logic       sf_q;
  logic [7:0] byte_q;
  logic       adv;     // input register item handled this cycle

  assign in_i.ready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      sf_q   <= in_i.start_frame;
      byte_q <= in_i.compressed_byte;
    end
  end

  // ---------------- decode state ----------------
  mode_e       mode_q, mode_d;
  logic [7:0]  lit_q, lit_d;
  logic [7:0]  run_q, run_d;
  logic [13:0] col_q, col_d;
  logic [2:0]  pl_q, pl_d;
  logic [15:0] row_q, row_d;
  logic        halted_q, halted_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_HEADER;
      lit_q    <= '0;
      run_q    <= '0;
      col_q    <= '0;
      pl_q     <= '0;
      row_q    <= '0;
      halted_q <= 1'b0;
    end else if (adv) begin
      mode_q   <= mode_d;
      lit_q    <= lit_d;
      run_q    <= run_d;
      col_q    <= col_d;
      pl_q     <= pl_d;
      row_q    <= row_d;
      halted_q <= halted_d;
    end
  end

  // ---------------- compute stage ----------------
  logic        out_v_q;
  logic        emit;       // this byte yields a result beat
  logic        hdr_err;    // header overruns the line
  logic [7:0]  hdr_cnt;
  logic [7:0]  wr_cnt;
  logic [13:0] col_sum;
  logic [2:0]  pl_inc;
  logic [15:0] row_inc;
  logic        line_done, frame_done, stop;
  // values seen by this byte after an optional frame restart
  mode_e       mode_e_v;
  logic [7:0]  lit_e, run_e;
  logic [13:0] col_e;
  logic [2:0]  pl_e;
  logic [15:0] row_e;
  logic        halt_e;

  always_comb begin
    if (sf_q) begin
      mode_e_v = MODE_HEADER;
      lit_e    = '0;
      run_e    = '0;
      col_e    = '0;
      pl_e     = '0;
      row_e    = '0;
      halt_e   = 1'b0;
    end else begin
      mode_e_v = mode_q;
      lit_e    = lit_q;
      run_e    = run_q;
      col_e    = col_q;
      pl_e     = pl_q;
      row_e    = row_q;
      halt_e   = halted_q;
    end

    stop = halt_e || (row_e >= height_q);

    // header count: 1-n for negative n, n+1 otherwise
    hdr_cnt = byte_q[7] ? 8'(~byte_q + 8'd2) : 8'(byte_q + 8'd1);
    hdr_err = ({1'b0, col_e} + 15'(hdr_cnt)) > {1'b0, line_len};

    wr_cnt = (mode_e_v == MODE_RUN) ? run_e : 8'd1;

    // position advance for a data write
    col_sum    = col_e + 14'(wr_cnt);
    pl_inc     = pl_e + 3'd1;
    row_inc    = row_e + 16'd1;
    line_done  = 1'b0;
    frame_done = 1'b0;

    mode_d   = mode_e_v;
    lit_d    = lit_e;
    run_d    = run_e;
    col_d    = col_e;
    pl_d     = pl_e;
    row_d    = row_e;
    halted_d = halt_e;
    emit     = 1'b0;

    if (!stop) begin
      unique case (mode_e_v)
        MODE_RUN, MODE_LITERAL: begin
          emit = 1'b1;
          if (mode_e_v == MODE_RUN) begin
            mode_d = MODE_HEADER;
          end else begin
            lit_d = lit_e - 8'd1;
            if (lit_d == 8'd0) mode_d = MODE_HEADER;
          end
          col_d = col_sum;
          if (col_sum >= line_len) begin
            line_done = 1'b1;
            col_d     = '0;
            pl_d      = pl_inc;
            if (pl_inc == 3'd0 || {1'b0, pl_inc} >= plane_cnt) begin
              pl_d  = '0;
              row_d = row_inc;
              if (row_inc == 16'd0 || row_inc >= height_q) begin
                frame_done = 1'b1;
                // row counter wrapped: park at the top so the frame stays done
                if (row_inc == 16'd0) row_d = 16'hFFFF;
              end
            end
          end
        end
        MODE_HEADER: begin
          if (hdr_err) begin
            emit     = 1'b1;
            halted_d = 1'b1;
          end else if (byte_q[7]) begin
            run_d  = hdr_cnt;
            mode_d = MODE_RUN;
          end else begin
            lit_d  = hdr_cnt;
            mode_d = MODE_LITERAL;
          end
        end
        default: begin
          mode_d = MODE_HEADER;
        end
      endcase
    end

    // hold the byte only when it has a result and the output slot stays full
    adv = in_v_q && (!emit || !out_v_q || out_o.ready);
  end

  // ---------------- result register ----------------
  logic        is_err;
  logic [7:0]  val_q, rep_q;
  logic [2:0]  opl_q;
  logic [15:0] orow_q;
  logic [12:0] ocol_q;
  logic        le_q, fe_q, err_q;

  assign is_err = (mode_e_v == MODE_HEADER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && emit) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      val_q  <= is_err ? 8'd0 : byte_q;
      rep_q  <= is_err ? hdr_cnt : wr_cnt;
      opl_q  <= pl_e;
      orow_q <= row_e;
      ocol_q <= col_e[12:0];
      le_q   <= !is_err && line_done;
      fe_q   <= !is_err && frame_done;
      err_q  <= is_err;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.value        = val_q;
  assign out_o.repeat_res   = rep_q;
  assign out_o.plane        = opl_q;
  assign out_o.row          = orow_q;
  assign out_o.column       = ocol_q;
  assign out_o.line_end     = le_q;
  assign out_o.frame_end    = fe_q;
  assign out_o.format_error = err_q;

  // ---------------- checks ----------------
  `PBR1_ASSERT(a_err_halts, (adv && emit && is_err) |=> halted_q, "overrun did not halt")
  `PBR1_NEVER(a_col_range, col_q >= LineMax, "column position beyond widest line")
  `PBR1_NEVER(a_frame_line, out_v_q && fe_q && !le_q, "frame end without line end")
  `PBR1_NEVER(a_lit_cnt, mode_q == MODE_LITERAL && lit_q == 8'd0, "literal mode, no bytes left")

endmodule
